// ----- rtl/sha_pkg.sv -----
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS_LOAD,
        ST_DIG_LOAD,
        ST_DIG_LOAD2,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } sha_state_t;

    localparam int unsigned WordW   = 32;
    localparam int unsigned Words   = 8;
    localparam int unsigned BlkWords = 16;
    localparam logic [7:0]  PadMark = 8'h80;
    localparam logic [5:0]  LenOffset = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_word(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        init_word = v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        round_k = k;
    endfunction

endpackage

// ----- rtl/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// Streaming SHA-256 hasher. Each input beat carries an optional restart, an optional
// message byte and an optional digest request, applied in that order. A byte that does
// not complete a 64-byte block is taken with no stall. A byte that completes a block holds
// the input while the block is loaded, run through 64 rounds of the shared round unit and
// given its final add. A digest request adds such a load, 64 rounds and a final add per
// padded block (one block, or two when 56 or more bytes are buffered) and then eight output
// beats, word 0 first, each paced by m_axis_tready; the running hash is left untouched. The
// block accepts no input beat while it compresses or delivers a digest.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_axis_tuser,   // [0] has_byte, [1] restart, [2] want_digest
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    sha_state_t  state_reg, state_next;
    logic [31:0] cv_reg  [Words];
    logic [31:0] hv_reg  [Words];
    logic [31:0] st_reg  [Words];
    logic [31:0] win_reg [BlkWords];
    logic [31:0] blk_reg [BlkWords];
    logic [5:0]  fill_reg;
    logic [63:0] total_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        dig_pend_reg;
    logic        second_reg;
    logic        kind_dig_reg;

    logic        in_beat, out_beat;
    logic        has_byte, restart, want_digest;
    logic [5:0]  fill_eff;
    logic [63:0] total_eff;
    logic        blk_full;
    logic [63:0] bit_len;
    logic [31:0] pad1 [BlkWords];
    logic [31:0] pad2 [BlkWords];
    logic [31:0] t1, t2, w_new;

    assign has_byte    = s_axis_tuser[0];
    assign restart     = s_axis_tuser[1];
    assign want_digest = s_axis_tuser[2];
    assign in_beat     = s_axis_tvalid && s_axis_tready;
    assign out_beat    = m_axis_tvalid && m_axis_tready;
    assign fill_eff    = restart ? 6'd0 : fill_reg;
    assign total_eff   = restart ? 64'd0 : total_reg;
    assign blk_full    = has_byte && (fill_eff == 6'd63);
    assign bit_len     = {total_reg[60:0], 3'b000};

    // Build the padded blocks from the buffer, the mark and the bit length
    always_comb begin
        for (int i = 0; i < BlkWords; i++) begin
            for (int j = 0; j < 4; j++) begin
                logic [5:0] p;
                logic [7:0] b;
                logic [7:0] lb;
                p  = 6'(4 * i + j);
                lb = bit_len[8 * (7 - ((4 * i + j) & 7)) +: 8];
                if (p < fill_reg) begin
                    b = blk_reg[i][8 * (3 - j) +: 8];
                end else if (p == fill_reg) begin
                    b = PadMark;
                end else if (p >= LenOffset && fill_reg < LenOffset) begin
                    b = lb;
                end else begin
                    b = 8'h00;
                end
                pad1[i][8 * (3 - j) +: 8] = b;
                pad2[i][8 * (3 - j) +: 8] = (p >= LenOffset) ? lb : 8'h00;
            end
        end
    end

    // Shared round unit and message schedule step
    assign t1 = st_reg[7] + big_sigma1(st_reg[4])
              + ((st_reg[4] & st_reg[5]) ^ (~st_reg[4] & st_reg[6]))
              + round_k(rnd_reg) + win_reg[0];
    assign t2 = big_sigma0(st_reg[0])
              + ((st_reg[0] & st_reg[1]) ^ (st_reg[0] & st_reg[2]) ^ (st_reg[1] & st_reg[2]));
    assign w_new = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9]
                 + small_sigma1(win_reg[14]);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_beat) begin
                    if (blk_full) begin
                        state_next = ST_ABS_LOAD;
                    end else if (want_digest) begin
                        state_next = ST_DIG_LOAD;
                    end
                end
            ST_ABS_LOAD, ST_DIG_LOAD, ST_DIG_LOAD2:
                state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == 6'd63) begin
                    state_next = ST_FINAL;
                end
            ST_FINAL:
                if (!kind_dig_reg) begin
                    state_next = dig_pend_reg ? ST_DIG_LOAD : ST_IDLE;
                end else begin
                    state_next = second_reg ? ST_DIG_LOAD2 : ST_OUT;
                end
            ST_OUT:
                if (out_beat && idx_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_OUT);
        m_axis_tdata  = hv_reg[idx_reg];
        m_axis_tuser  = idx_reg;
        m_axis_tlast  = (idx_reg == 3'd7);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= 6'd0;
            total_reg    <= 64'd0;
            rnd_reg      <= 6'd0;
            idx_reg      <= 3'd0;
            dig_pend_reg <= 1'b0;
            second_reg   <= 1'b0;
            kind_dig_reg <= 1'b0;
            for (int i = 0; i < Words; i++) begin
                cv_reg[i] <= init_word(3'(i));
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (in_beat) begin
                        dig_pend_reg <= want_digest;
                        fill_reg     <= has_byte ? fill_eff + 6'd1 : fill_eff;
                        total_reg    <= has_byte ? total_eff + 64'd1 : total_eff;
                        if (restart) begin
                            for (int i = 0; i < Words; i++) begin
                                cv_reg[i] <= init_word(3'(i));
                            end
                        end
                    end
                ST_ABS_LOAD:
                begin
                    kind_dig_reg <= 1'b0;
                    rnd_reg      <= 6'd0;
                end
                ST_DIG_LOAD:
                begin
                    kind_dig_reg <= 1'b1;
                    dig_pend_reg <= 1'b0;
                    second_reg   <= (fill_reg >= LenOffset);
                    rnd_reg      <= 6'd0;
                end
                ST_DIG_LOAD2:
                begin
                    second_reg <= 1'b0;
                    rnd_reg    <= 6'd0;
                end
                ST_ROUND:
                    rnd_reg <= rnd_reg + 6'd1;
                ST_FINAL:
                begin
                    idx_reg <= 3'd0;
                    if (!kind_dig_reg) begin
                        for (int i = 0; i < Words; i++) begin
                            cv_reg[i] <= hv_reg[i] + st_reg[i];
                        end
                    end
                end
                ST_OUT:
                    if (out_beat) begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers: buffer, schedule window, working and result words
    always_ff @(posedge clk) begin
        unique case (state_reg)
            ST_IDLE:
                if (in_beat && has_byte) begin
                    blk_reg[fill_eff[5:2]][{~fill_eff[1:0], 3'b000} +: 8] <= s_axis_tdata;
                end
            ST_ABS_LOAD, ST_DIG_LOAD:
                for (int i = 0; i < BlkWords; i++) begin
                    win_reg[i] <= (state_reg == ST_ABS_LOAD) ? blk_reg[i] : pad1[i];
                    if (i < Words) begin
                        st_reg[i] <= cv_reg[i];
                        hv_reg[i] <= cv_reg[i];
                    end
                end
            ST_DIG_LOAD2:
                for (int i = 0; i < BlkWords; i++) begin
                    win_reg[i] <= pad2[i];
                    if (i < Words) begin
                        st_reg[i] <= hv_reg[i];
                    end
                end
            ST_ROUND:
            begin
                for (int i = 0; i < BlkWords - 1; i++) begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[BlkWords - 1] <= w_new;
                st_reg[7] <= st_reg[6];
                st_reg[6] <= st_reg[5];
                st_reg[5] <= st_reg[4];
                st_reg[4] <= st_reg[3] + t1;
                st_reg[3] <= st_reg[2];
                st_reg[2] <= st_reg[1];
                st_reg[1] <= st_reg[0];
                st_reg[0] <= t1 + t2;
            end
            ST_FINAL:
                for (int i = 0; i < Words; i++) begin
                    hv_reg[i] <= hv_reg[i] + st_reg[i];
                end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/sha_checker.sv -----
`timescale 1ns / 1ps
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    // Never take input while a digest is being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready during digest output");

    // Mark the last beat exactly on word seven
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast does not match word index");

    // Advance the word index by one between beats
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("word index skipped");

    // Return to ready after the last word
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after digest");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import sha_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       want_digest;
        logic       restart;
        logic       has_byte;
    } hash_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam int WatchLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    hash_beat_t   pending_beats[$];
    digest_beat_t expected_words[$];
    logic [31:0]  hash_h [8] = InitH;
    logic [7:0]   msg_block [64];
    int unsigned  block_fill = 0;
    logic [63:0]  msg_bytes = '0;
    int           errors = 0;
    int           send_wait;
    int           recv_wait;
    int           idle_cycles;
    bit           stim_done;

    sha256_stream_hasher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run one 64-round compression of a block into a hash value
    function automatic void sha_compress(ref logic [31:0] hv [8], input logic [7:0] blk [64]);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
        {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + RoundK[t] + w[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    // Advance the running hash for one beat and queue any digest words
    task automatic predict_beat(input hash_beat_t it);
        logic [31:0] dig [8];
        logic [7:0]  pad [64];
        logic [63:0] bits;
        digest_beat_t r;
        if (it.restart) begin
            hash_h = InitH;
            block_fill = 0;
            msg_bytes = '0;
        end
        if (it.has_byte) begin
            msg_block[block_fill] = it.data_byte;
            block_fill++;
            msg_bytes++;
            if (block_fill == 64) begin
                sha_compress(hash_h, msg_block);
                block_fill = 0;
            end
        end
        if (it.want_digest) begin
            dig = hash_h;
            bits = msg_bytes << 3;
            for (int i = 0; i < 64; i++) pad[i] = (i < block_fill) ? msg_block[i] : 8'h00;
            pad[block_fill] = 8'h80;
            if (block_fill >= 56) begin
                sha_compress(dig, pad);
                for (int i = 0; i < 64; i++) pad[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) pad[56+i] = bits[63-8*i -: 8];
            sha_compress(dig, pad);
            for (int i = 0; i < 8; i++) begin
                r.digest_word = dig[i];
                r.word_index = 3'(i);
                r.last_word = (i == 7);
                expected_words.push_back(r);
            end
        end
    endtask

    function automatic hash_beat_t mk(input logic [7:0] d, input bit hb, input bit rs,
                                      input bit wd);
        hash_beat_t it;
        it.data_byte = d; it.has_byte = hb; it.restart = rs; it.want_digest = wd;
        return it;
    endfunction

    // Fill the stimulus queue: directed cases, then random messages
    initial begin
        int n;
        stim_done = 1'b0;
        // Digest of empty message, then after restart too
        pending_beats.push_back(mk(8'hff, 1'b0, 1'b0, 1'b1));
        pending_beats.push_back(mk(8'h00, 1'b0, 1'b1, 1'b1));
        pending_beats.push_back(mk(8'h00, 1'b1, 1'b1, 1'b0));
        pending_beats.push_back(mk(8'hff, 1'b1, 1'b0, 1'b1));
        pending_beats.push_back(mk(8'h61, 1'b1, 1'b1, 1'b1));
        pending_beats.push_back(mk(8'h55, 1'b0, 1'b0, 1'b0));
        pending_beats.push_back(mk(8'haa, 1'b1, 1'b0, 1'b1));
        // Fill to 56 and to 63 bytes for the two-block padding, then cross a block
        for (int i = 0; i < 70; i++)
            pending_beats.push_back(mk(8'($urandom), 1'b1, i == 0,
                                       i == 55 || i == 62 || i == 63 || i == 69));
        while (pending_beats.size() < 245) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 140) : $urandom_range(0, 30);
            pending_beats.push_back(mk(8'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                                       $urandom_range(0, 3) == 0));
            for (int i = 0; i < n; i++)
                pending_beats.push_back(mk(8'($urandom), $urandom_range(0, 9) != 0, 1'b0,
                                           $urandom_range(0, 11) == 0 || i == n - 1));
        end
        stim_done = 1'b1;
    end

    // Driver: present queued beats with random gaps
    always @(posedge clk or negedge rst_n) begin
        int gap;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_wait <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_beat(pending_beats.pop_front());
                gap = $urandom_range(0, 7);
            end else begin
                gap = send_wait;
            end
            if (gap == 0 && stim_done && pending_beats.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                {s_axis_tdata, s_axis_tuser} <= pending_beats[0];
                send_wait <= 0;
            end else begin
                s_axis_tvalid <= 1'b0;
                send_wait <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // Monitor: random stall on the result side, check each word
    always @(posedge clk or negedge rst_n) begin
        digest_beat_t got, exp_w;
        int w;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h idx %0d last %0b", $time,
                             got.digest_word, got.word_index, got.last_word);
                    errors++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w) begin
                        $display("%0t: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                                 $time, exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                                 got.digest_word, got.word_index, got.last_word);
                        errors++;
                    end
                end
                w = $urandom_range(0, 7);
                recv_wait <= w;
                m_axis_tready <= (w == 0);
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_axis_tready <= (recv_wait == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on accepted beats
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while ((pending_beats.size() > 0 || expected_words.size() > 0)
               && idle_cycles < WatchLimit)
            @(posedge clk);
        if (idle_cycles >= WatchLimit) begin
            $display("tb_top NOT OK");
        end else begin
            repeat (200) @(posedge clk);
            if (errors == 0 && expected_words.size() == 0)
                $display("tb_top OK");
            else
                $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
